### design/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

   localparam int PHASE_BITS_DEFAULT = 16;

   localparam int SINE_DEPTH    = 256;
   localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH);
   localparam int SINE_Q_BITS   = 15;
   localparam int SINE_BITS     = SINE_Q_BITS + 1;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_COUNT      = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RED_BASE_AMP   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GREEN_BASE_AMP = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLUE_BASE_AMP  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RED_RATE       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GREEN_RATE     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLUE_RATE      = 3'd5;

   localparam longint unsigned Q30_A = 64'd1686629713;
   localparam longint unsigned Q30_B = 64'd693598669;
   localparam longint unsigned Q30_C = 64'd85569306;
   localparam longint unsigned Q30_D = 64'd5026995;
   localparam longint unsigned Q30_E = 64'd172271;

   typedef logic [SINE_Q_BITS-1:0] rom_type [0:SINE_DEPTH];
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   // quarter-wave sine, Q0.15 magnitude, evaluated by polynomial at elaboration
   function automatic rom_type build_rom();
      rom_type         rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned p;
      longint unsigned y;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         x  = (longint'(k) << 30) / SINE_DEPTH;
         x2 = (x * x) >> 30;
         p  = Q30_D - ((x2 * Q30_E) >> 30);
         p  = Q30_C - ((x2 * p) >> 30);
         p  = Q30_B - ((x2 * p) >> 30);
         p  = Q30_A - ((x2 * p) >> 30);
         y  = (x * p) >> 30;
         y  = (y * 64'd32767 + (64'd1 << 29)) >> 30;
         if (y > 64'd32767) begin
            y = 64'd32767;
         end
         rom[k] = SINE_Q_BITS'(y);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

endpackage

### design/scp_sine.sv
`timescale 1ns / 1ps

module scp_sine #(
   parameter int PHASE_BITS = scp_pkg::PHASE_BITS_DEFAULT
) (
   input  logic [PHASE_BITS-1:0]                 phase,
   output logic signed [scp_pkg::SINE_BITS-1:0]  sine
);

   localparam int IW = scp_pkg::SINE_IDX_BITS;

   logic [PHASE_BITS+IW+1:0]         scaled;
   logic [IW+1:0]                    idx;
   logic [1:0]                       quad;
   logic [IW-1:0]                    k;
   logic [IW:0]                      addr;
   logic [scp_pkg::SINE_Q_BITS-1:0]  mag;

   assign scaled = {phase, {(IW + 2){1'b0}}};
   assign idx    = scaled[PHASE_BITS+IW+1:PHASE_BITS];
   assign quad   = idx[IW+1:IW];
   assign k      = idx[IW-1:0];
   assign addr   = quad[0] ? ((IW + 1)'(scp_pkg::SINE_DEPTH) - {1'b0, k}) : {1'b0, k};
   assign mag    = scp_pkg::SINE_ROM[addr];
   assign sine   = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

### design/scp_lane.sv
`timescale 1ns / 1ps

module scp_lane #(
   parameter int PHASE_BITS = scp_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [15:0]           frame_time,
   input  scp_pkg::csr_data_type base_amp,
   input  scp_pkg::csr_data_type rate,
   output logic [7:0]            level
);

   logic [PHASE_BITS-1:0]                phase_ff;
   logic [PHASE_BITS-1:0]                phase_in;
   logic [31:0]                          prod;
   logic [23:0]                          inc;
   logic signed [scp_pkg::SINE_BITS-1:0] sine;
   logic signed [8:0]                    amp;
   logic signed [24:0]                   wave;
   logic signed [25:0]                   sum;

   assign prod     = 32'(rate) * 32'(frame_time);
   assign inc      = prod[31:8];
   assign phase_in = step ? (phase_ff + PHASE_BITS'(32'(inc))) : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   scp_sine #(
      .PHASE_BITS (PHASE_BITS)
   ) u_sine (
      .phase (phase_ff),
      .sine  (sine)
   );

   assign amp  = $signed({1'b0, base_amp[7:0]});
   assign wave = amp * sine;
   assign sum  = $signed({3'b000, base_amp[15:8], 15'd0}) + 26'(wave);

   always_comb begin
      if (sum[25]) begin
         level = 8'd0;
      end else if (|sum[24:23]) begin
         level = 8'd255;
      end else begin
         level = sum[22:15];
      end
   end

endmodule

### design/sine_rgb_colour_pulse_core.sv
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its request is taken.
// Throughput: one request per cycle; the result register frees as it is read,
// so a new request is taken whenever the result side is empty or taking.
// Reset clears the three phases, all control registers and the result valid.
// Levels use the phases held before the request; phases advance on accept.

module sine_rgb_colour_pulse_core #(
   parameter int PHASE_BITS = scp_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [15:0]                            req_tdata,   // frame_time
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [23:0]                            rsp_tdata,   // red, green, blue level
   input  logic                                   csr_we,
   input  logic [scp_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  scp_pkg::csr_data_type                  csr_wdata
);

   scp_pkg::csr_data_type csr_ff [0:scp_pkg::CSR_COUNT-1];
   logic                  accept;
   logic [7:0]            red_level;
   logic [7:0]            green_level;
   logic [7:0]            blue_level;
   logic                  rsp_tvalid_ff;
   logic                  rsp_tvalid_in;
   logic [23:0]           rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < scp_pkg::CSR_COUNT; i++) begin
            csr_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            scp_pkg::CSR_RED_BASE_AMP:   csr_ff[0] <= csr_wdata;
            scp_pkg::CSR_GREEN_BASE_AMP: csr_ff[1] <= csr_wdata;
            scp_pkg::CSR_BLUE_BASE_AMP:  csr_ff[2] <= csr_wdata;
            scp_pkg::CSR_RED_RATE:       csr_ff[3] <= csr_wdata;
            scp_pkg::CSR_GREEN_RATE:     csr_ff[4] <= csr_wdata;
            scp_pkg::CSR_BLUE_RATE:      csr_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   scp_lane #(.PHASE_BITS (PHASE_BITS)) u_red (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .frame_time (req_tdata),
      .base_amp   (csr_ff[0]),
      .rate       (csr_ff[3]),
      .level      (red_level)
   );

   scp_lane #(.PHASE_BITS (PHASE_BITS)) u_green (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .frame_time (req_tdata),
      .base_amp   (csr_ff[1]),
      .rate       (csr_ff[4]),
      .level      (green_level)
   );

   scp_lane #(.PHASE_BITS (PHASE_BITS)) u_blue (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .frame_time (req_tdata),
      .base_amp   (csr_ff[2]),
      .rate       (csr_ff[5]),
      .level      (blue_level)
   );

   assign rsp_tvalid_in = accept || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= {blue_level, green_level, red_level};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### bench/tb_sine_rgb_colour_pulse_core.sv
`timescale 1ns / 1ps

module tb_sine_rgb_colour_pulse_core;

   localparam int PHASE_W        = 16;
   localparam int TABLE_D        = 256;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_SETTINGS = 12;
   localparam int TICKS_PER_SETTING = 162;

   // sin(pi/2 * x) Taylor terms, Q30
   localparam longint unsigned TAYLOR_1 = 64'd1686629713;
   localparam longint unsigned TAYLOR_3 = 64'd693598669;
   localparam longint unsigned TAYLOR_5 = 64'd85569306;
   localparam longint unsigned TAYLOR_7 = 64'd5026995;
   localparam longint unsigned TAYLOR_9 = 64'd172271;

   localparam logic [scp_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [scp_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } colour_set_type;

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [15:0]                          req_tdata  = '0;   // frame_time
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [23:0]                          rsp_tdata;         // red, green, blue level
   logic                                 csr_we     = 1'b0;
   logic [scp_pkg::CSR_INDEX_BITS-1:0]   csr_index  = '0;
   scp_pkg::csr_data_type                csr_wdata  = '0;

   logic [14:0]   quarter_sine [0:TABLE_D];
   logic [15:0]   base_amp [3];
   logic [15:0]   rate_reg [3];
   logic [15:0]   phase_acc [3];

   logic [15:0]      frame_queue [$];
   colour_set_type   expected_levels [$];

   bit            send_gaps;
   bit            recv_stalls;
   int            send_gap;
   int            stall_left;
   int            idle_cycles;
   int            mismatch_count;
   int            result_count;
   int            tick_count;
   int            setting_count;

   sine_rgb_colour_pulse_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [14:0] wave_point(input int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned p;
      longint unsigned y;
      x  = k;
      x  = (x << 30) / TABLE_D;
      x2 = (x * x) >> 30;
      p  = TAYLOR_7 - ((x2 * TAYLOR_9) >> 30);
      p  = TAYLOR_5 - ((x2 * p) >> 30);
      p  = TAYLOR_3 - ((x2 * p) >> 30);
      p  = TAYLOR_1 - ((x2 * p) >> 30);
      y  = (x * p) >> 30;
      y  = (y * 64'd32767 + (64'd1 << 29)) >> 30;
      if (y > 64'd32767) begin
         y = 64'd32767;
      end
      return y[14:0];
   endfunction

   function automatic logic [7:0] colour_level(input logic [15:0] ba, input logic [15:0] ph);
      longint unsigned idx;
      longint          s;
      longint          base_v;
      longint          amp_v;
      longint          lvl;
      int              quad;
      int              k;
      idx    = ph;
      idx    = (idx * 4 * TABLE_D) >> PHASE_W;
      quad   = int'((idx / TABLE_D) % 4);
      k      = int'(idx % TABLE_D);
      case (quad)
         0: s = quarter_sine[k];
         1: s = quarter_sine[TABLE_D - k];
         2: s = -longint'(quarter_sine[k]);
         default: s = -longint'(quarter_sine[TABLE_D - k]);
      endcase
      base_v = ba[15:8];
      amp_v  = ba[7:0];
      lvl    = (base_v * 32768 + amp_v * s) >>> 15;
      if (lvl < 0) begin
         lvl = 0;
      end else if (lvl > 255) begin
         lvl = 255;
      end
      return lvl[7:0];
   endfunction

   task automatic predict_tick(input logic [15:0] ft);
      colour_set_type levels;
      logic [31:0] step;
      levels.red   = colour_level(base_amp[0], phase_acc[0]);
      levels.green = colour_level(base_amp[1], phase_acc[1]);
      levels.blue  = colour_level(base_amp[2], phase_acc[2]);
      expected_levels.push_back(levels);
      for (int c = 0; c < 3; c++) begin
         step         = (32'(rate_reg[c]) * 32'(ft)) >> 8;
         phase_acc[c] = phase_acc[c] + step[15:0];
      end
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
               $time, what, result_count, want, got);
      mismatch_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick_frame_time();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(0, 16'h03FF));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_register();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {8'hFF, 8'($urandom)};
         3: return {8'($urandom), 8'hFF};
         4: return {8'h00, 8'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_csr(input logic [scp_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx < scp_pkg::CSR_RED_RATE) begin
         base_amp[idx[1:0]] = val;
      end else if (idx < scp_pkg::CSR_COUNT) begin
         rate_reg[2'(idx - scp_pkg::CSR_RED_RATE)] = val;
      end
   endtask

   task automatic program_colours(input logic [15:0] red_ba, input logic [15:0] green_ba,
                                  input logic [15:0] blue_ba, input logic [15:0] red_rate,
                                  input logic [15:0] green_rate, input logic [15:0] blue_rate);
      write_csr(CSR_UNMAPPED_LO, 16'($urandom));
      write_csr(scp_pkg::CSR_RED_BASE_AMP, red_ba);
      write_csr(scp_pkg::CSR_GREEN_BASE_AMP, green_ba);
      write_csr(scp_pkg::CSR_BLUE_BASE_AMP, blue_ba);
      write_csr(scp_pkg::CSR_RED_RATE, red_rate);
      write_csr(scp_pkg::CSR_GREEN_RATE, green_rate);
      write_csr(scp_pkg::CSR_BLUE_RATE, blue_rate);
      write_csr(CSR_UNMAPPED_HI, 16'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      setting_count++;
   endtask

   task automatic wait_idle();
      while (frame_queue.size() != 0 || req_tvalid || expected_levels.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   // request driver; expectations are formed as each request is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata);
            tick_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (frame_queue.size() != 0) begin
               req_tdata  <= frame_queue.pop_front();
               req_tvalid <= 1'b1;
               if (send_gaps) begin
                  send_gap = pick_gap();
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      colour_set_type got;
      colour_set_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_levels.size() == 0) begin
               $display("%0t: result %0d arrived with nothing expected", $time, result_count);
               mismatch_count++;
            end else begin
               want = expected_levels.pop_front();
               if (got.red !== want.red) begin
                  report_mismatch("red_level", want.red, got.red);
               end
               if (got.green !== want.green) begin
                  report_mismatch("green_level", want.green, got.green);
               end
               if (got.blue !== want.blue) begin
                  report_mismatch("blue_level", want.blue, got.blue);
               end
            end
            result_count++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (recv_stalls && $urandom_range(0, 5) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("sine_rgb_colour_pulse_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int k = 0; k <= TABLE_D; k++) begin
         quarter_sine[k] = wave_point(k);
      end
      for (int c = 0; c < 3; c++) begin
         base_amp[c]  = '0;
         rate_reg[c]  = '0;
         phase_acc[c] = '0;
      end
      send_gaps   = 1'b1;
      recv_stalls = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: all levels zero, phases frozen
      frame_queue.push_back(16'h0100);
      frame_queue.push_back(16'hFFFF);
      wait_idle();

      // red steps a quarter turn per frame and clips at both ends, green wraps fast
      program_colours(16'h80FF, 16'h00FF, 16'hFFFF, 16'h4000, 16'hFFFF, 16'h0001);
      for (int i = 0; i < 5; i++) begin
         frame_queue.push_back(16'h0100);
      end
      frame_queue.push_back(16'h0000);
      frame_queue.push_back(16'hFFFF);
      frame_queue.push_back(16'h8000);
      frame_queue.push_back(16'h0001);
      frame_queue.push_back(16'h00FF);
      frame_queue.push_back(16'h0080);
      frame_queue.push_back(16'h7FFF);
      wait_idle();

      program_colours(16'hFF00, 16'h0000, 16'h7F80, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      frame_queue.push_back(16'hFFFF);
      frame_queue.push_back(16'hFFFF);
      frame_queue.push_back(16'hAAAA);
      frame_queue.push_back(16'h5555);
      frame_queue.push_back(16'h0001);
      wait_idle();

      for (int s = 0; s < RANDOM_SETTINGS; s++) begin
         program_colours(pick_register(), pick_register(), pick_register(),
                         pick_register(), pick_register(), pick_register());
         send_gaps   = ($urandom_range(0, 3) != 0);
         recv_stalls = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < TICKS_PER_SETTING; i++) begin
            frame_queue.push_back(pick_frame_time());
         end
         wait_idle();
      end

      if (expected_levels.size() != 0) begin
         $display("%0d expected results never arrived", expected_levels.size());
         mismatch_count++;
      end
      $display("Ran %0d frame ticks over %0d register settings, %0d colour results checked",
               tick_count, setting_count, result_count);
      $display("Mismatches found: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("sine_rgb_colour_pulse_core verification clean");
      end else begin
         $display("sine_rgb_colour_pulse_core verification failed");
      end
      $finish;
   end

endmodule

### sine_rgb_colour_pulse_core.f
design/scp_pkg.sv
design/scp_sine.sv
design/scp_lane.sv
design/sine_rgb_colour_pulse_core.sv
bench/tb_sine_rgb_colour_pulse_core.sv
